// File: hw/rtl/line_rasterizer_assert.svh
// assertion helpers for the line rasterizer
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LR_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LR_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: hw/rtl/lr_pkg.sv
`default_nettype none
package lr_pkg;

    localparam int COORD_BITS  = 11;
    localparam int LEN_BITS    = COORD_BITS + 1;
    localparam int ADDR_BITS   = 22;
    localparam int WIDTH_BITS  = 12;
    localparam int STEP_BITS   = WIDTH_BITS + 1;
    localparam int COLOR_BITS  = 32;

    localparam logic [WIDTH_BITS-1:0] SURFACE_WIDTH_RESET = WIDTH_BITS'(320);

    // mode codes carried in tuser
    localparam logic MODE_LINE = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // input tdata layout
    localparam int SX_LSB       = 0;
    localparam int SY_LSB       = SX_LSB + COORD_BITS;
    localparam int EX_LSB       = SY_LSB + COORD_BITS;
    localparam int EY_LSB       = EX_LSB + COORD_BITS;
    localparam int COLOR_LSB    = EY_LSB + COORD_BITS;
    localparam int IN_USED_BITS = COLOR_LSB + COLOR_BITS;
    localparam int IN_DATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_USED_BITS = ADDR_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    // register port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_SURFACE_WIDTH = 1'b0;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [LEN_BITS-1:0]  pixels_left;
        logic [LEN_BITS-1:0]  error_sum;
        logic [LEN_BITS-1:0]  major_len;
        logic [LEN_BITS-1:0]  minor_len;
        logic [STEP_BITS-1:0] major_step;
        logic [STEP_BITS-1:0] minor_step;
    } t_line_state;

    function automatic logic [ADDR_BITS-1:0] sext_step(input logic [STEP_BITS-1:0] step);
        return {{(ADDR_BITS - STEP_BITS){step[STEP_BITS-1]}}, step};
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lr_setup.sv
`default_nettype none
module lr_setup (
    input  logic [lr_pkg::COORD_BITS-1:0] i_start_x,
    input  logic [lr_pkg::COORD_BITS-1:0] i_start_y,
    input  logic [lr_pkg::COORD_BITS-1:0] i_end_x,
    input  logic [lr_pkg::COORD_BITS-1:0] i_end_y,
    input  logic [lr_pkg::WIDTH_BITS-1:0] i_surface_width,
    output lr_pkg::t_line_state           o_state
);
    import lr_pkg::*;

    logic [COORD_BITS-1:0]            adx;
    logic [COORD_BITS-1:0]            ady;
    logic [STEP_BITS-1:0]             xstep;
    logic [STEP_BITS-1:0]             ystep;
    logic [LEN_BITS-1:0]              xlen;
    logic [LEN_BITS-1:0]              ylen;
    logic [COORD_BITS+WIDTH_BITS-1:0] row_base;

    always_comb begin
        if (i_end_x >= i_start_x) begin
            adx   = i_end_x - i_start_x;
            xstep = STEP_BITS'(1);
        end else begin
            adx   = i_start_x - i_end_x;
            xstep = '1;
        end
        if (i_end_y >= i_start_y) begin
            ady   = i_end_y - i_start_y;
            ystep = {1'b0, i_surface_width};
        end else begin
            ady   = i_start_y - i_end_y;
            ystep = STEP_BITS'(0) - {1'b0, i_surface_width};
        end
        xlen = {1'b0, adx} + LEN_BITS'(1);
        ylen = {1'b0, ady} + LEN_BITS'(1);

        row_base = {{WIDTH_BITS{1'b0}}, i_start_y} * {{COORD_BITS{1'b0}}, i_surface_width};

        o_state.addr        = ADDR_BITS'(row_base) + ADDR_BITS'(i_start_x);
        o_state.error_sum   = '0;
        // equal spans go horizontal
        if (adx < ady) begin
            o_state.major_len  = ylen;
            o_state.minor_len  = xlen;
            o_state.major_step = ystep;
            o_state.minor_step = xstep;
        end else begin
            o_state.major_len  = xlen;
            o_state.minor_len  = ylen;
            o_state.major_step = xstep;
            o_state.minor_step = ystep;
        end
        o_state.pixels_left = o_state.major_len;
    end

endmodule
`default_nettype wire

// File: hw/rtl/lr_stepper.sv
`default_nettype none
module lr_stepper (
    input  lr_pkg::t_line_state i_state,
    output lr_pkg::t_line_state o_state,
    output logic                o_active,
    output logic                o_last
);
    import lr_pkg::*;

    logic [LEN_BITS-1:0]  err_sum;
    logic [LEN_BITS-1:0]  pixels_dec;
    logic                 err_wrap;
    logic [ADDR_BITS-1:0] addr_minor;

    always_comb begin
        err_sum    = i_state.error_sum + i_state.minor_len;
        err_wrap   = err_sum >= i_state.major_len;
        addr_minor = err_wrap ? i_state.addr + sext_step(i_state.minor_step) : i_state.addr;
        pixels_dec = i_state.pixels_left - LEN_BITS'(1);

        o_state             = i_state;
        o_state.error_sum   = err_wrap ? err_sum - i_state.major_len : err_sum;
        o_state.addr        = addr_minor + sext_step(i_state.major_step);
        o_state.pixels_left = pixels_dec;

        o_active = pixels_dec != '0;
        o_last   = i_state.pixels_left == LEN_BITS'(1);
    end

endmodule
`default_nettype wire

// File: hw/rtl/line_rasterizer.sv
// a step goes into the input register; its pixel is offered from the result register
// throughput: one item per clock while the output side keeps tready high
// line setup (one 11x12 multiply) and the per-pixel step each fit between the input
// register and the state/result registers, so the stepping state loop sets the rate
// reset (synchronous, active low): no line active, both stages empty, surface_width = 320
`default_nettype none
module line_rasterizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // start_x, start_y, end_x, end_y, line_color, zero pad
    input  logic [lr_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // mode
    input  logic                             s_axis_tuser,
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pixel_address, pixel_color, zero pad
    output logic [lr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    // last_pixel
    output logic                             m_axis_tlast,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lr_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [lr_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [lr_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                             pready
);
    import lr_pkg::*;

    // register file: surface_width only, decoded on the word index
    logic [WIDTH_BITS-1:0] r_surface_width;
    logic                  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == REG_SURFACE_WIDTH;
    assign prdata  = reg_sel ? APB_DATA_BITS'(r_surface_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surface_width <= SURFACE_WIDTH_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_surface_width <= pwdata[WIDTH_BITS-1:0];
        end
    end

    // input register stage
    logic                   r_in_valid;
    logic                   r_in_mode;
    logic [COORD_BITS-1:0]  r_in_start_x;
    logic [COORD_BITS-1:0]  r_in_start_y;
    logic [COORD_BITS-1:0]  r_in_end_x;
    logic [COORD_BITS-1:0]  r_in_end_y;
    logic [COLOR_BITS-1:0]  r_in_color;

    // output register stage
    logic                   r_out_valid;
    logic [ADDR_BITS-1:0]   r_out_addr;
    logic [COLOR_BITS-1:0]  r_out_color;
    logic                   r_out_last;

    // the item in the input stage moves on when the result slot is free or draining
    logic advance;
    logic in_xfer;
    logic step_emit;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_mode    <= s_axis_tuser;
            r_in_start_x <= s_axis_tdata[SX_LSB +: COORD_BITS];
            r_in_start_y <= s_axis_tdata[SY_LSB +: COORD_BITS];
            r_in_end_x   <= s_axis_tdata[EX_LSB +: COORD_BITS];
            r_in_end_y   <= s_axis_tdata[EY_LSB +: COORD_BITS];
            r_in_color   <= s_axis_tdata[COLOR_LSB +: COLOR_BITS];
        end
    end

    // line state
    logic                  r_line_active;
    t_line_state           r_line;
    logic [COLOR_BITS-1:0] r_held_color;

    t_line_state setup_state;
    t_line_state step_state;
    logic        step_active;
    logic        step_last;

    lr_setup u_setup (
        .i_start_x       (r_in_start_x),
        .i_start_y       (r_in_start_y),
        .i_end_x         (r_in_end_x),
        .i_end_y         (r_in_end_y),
        .i_surface_width (r_surface_width),
        .o_state         (setup_state)
    );

    lr_stepper u_stepper (
        .i_state  (r_line),
        .o_state  (step_state),
        .o_active (step_active),
        .o_last   (step_last)
    );

    // a step with no active line is dropped without a result
    assign step_emit = advance && (r_in_mode == MODE_STEP) && r_line_active;

    logic        n_line_active;
    t_line_state n_line;

    always_comb begin
        n_line_active = r_line_active;
        n_line        = r_line;
        if (advance) begin
            case (r_in_mode)
                MODE_LINE: begin
                    // a new command replaces any line in progress
                    n_line_active = 1'b1;
                    n_line        = setup_state;
                end
                MODE_STEP: begin
                    if (r_line_active) begin
                        n_line_active = step_active;
                        n_line        = step_state;
                    end
                end
                default: begin
                    n_line_active = r_line_active;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_line        <= '0;
            r_held_color  <= '0;
        end else begin
            r_line_active <= n_line_active;
            r_line        <= n_line;
            if (advance && (r_in_mode == MODE_LINE)) begin
                r_held_color <= r_in_color;
            end
        end
    end

    // result register: holds a pixel until its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_emit) begin
            r_out_addr  <= r_line.addr;
            r_out_color <= r_held_color;
            r_out_last  <= step_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_DATA_BITS'({r_out_color, r_out_addr});

`include "line_rasterizer_assert.svh"

    `LR_ASSERT_IMPLY(a_active_count, i_clk, i_rst_n, 1'b1, r_line_active == (r_line.pixels_left != '0), "line active flag disagrees with pixel count")
    `LR_ASSERT_IMPLY(a_error_bound, i_clk, i_rst_n, r_line_active, r_line.error_sum < r_line.major_len, "error sum reached major length")
    `LR_ASSERT_IMPLY(a_minor_le_major, i_clk, i_rst_n, r_line_active, r_line.minor_len <= r_line.major_len, "minor length exceeds major length")
    `LR_ASSERT_NEXT(a_last_ends_line, i_clk, i_rst_n, step_emit && step_last, !r_line_active && r_out_last, "line still active after its last pixel")

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lr_pkg::*;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 80;
    localparam int LONG_SPAN = 255;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    // register map: register i sits at byte address 4*i
    localparam int REG_SPARE = 1;
    localparam logic [APB_ADDR_BITS-1:0] SURFACE_WIDTH_ADDR =
        APB_ADDR_BITS'(int'(REG_SURFACE_WIDTH) * 4);
    localparam logic [APB_ADDR_BITS-1:0] SPARE_ADDR = APB_ADDR_BITS'(REG_SPARE * 4);

    // one input transfer: mode in tuser, the rest in tdata
    typedef struct packed {
        bit                   mode;
        bit [COORD_BITS-1:0]  sx;
        bit [COORD_BITS-1:0]  sy;
        bit [COORD_BITS-1:0]  ex;
        bit [COORD_BITS-1:0]  ey;
        bit [COLOR_BITS-1:0]  color;
    } t_cmd;

    // one framebuffer write
    typedef struct packed {
        bit [ADDR_BITS-1:0]   addr;
        bit [COLOR_BITS-1:0]  color;
        bit                   last;
    } t_pixel;

    // opening table: on step rows the color column is the expected pixel color
    typedef struct packed {
        bit                   typed;
        bit                   mode;
        bit [COORD_BITS-1:0]  sx;
        bit [COORD_BITS-1:0]  sy;
        bit [COORD_BITS-1:0]  ex;
        bit [COORD_BITS-1:0]  ey;
        bit [COLOR_BITS-1:0]  color;
        bit [ADDR_BITS-1:0]   want_addr;
        bit                   want_last;
    } t_opening_row;

    localparam int OPENING_ROWS = 26;

    // all rows run with the reset surface width of 320
    t_opening_row opening_table [OPENING_ROWS] = '{
        // step with no line active: nothing comes out
        '{0, MODE_STEP, 0, 0, 0, 0, 32'h0000_0000, 0, 0},
        // single point at the origin
        '{0, MODE_LINE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1},
        // line finished: a further step is dropped
        '{0, MODE_STEP, 2047, 2047, 2047, 2047, 32'hFFFF_FFFF, 0, 0},
        // single point at the far corner
        '{0, MODE_LINE, 2047, 2047, 2047, 2047, 32'h0000_0000, 0, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'h0000_0000, 657087, 1},
        // horizontal line, both endpoints drawn
        '{0, MODE_LINE, 5, 1, 7, 1, 32'hA5A5_A5A5, 0, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'hA5A5_A5A5, 325, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'hA5A5_A5A5, 326, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'hA5A5_A5A5, 327, 1},
        // vertical line going up, both endpoints drawn
        '{0, MODE_LINE, 3, 4, 3, 2, 32'h5A5A_5A5A, 0, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'h5A5A_5A5A, 1283, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'h5A5A_5A5A, 963, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'h5A5A_5A5A, 643, 1},
        // equal spans: horizontal is the major direction
        '{0, MODE_LINE, 0, 0, 2, 2, 32'h1234_5678, 0, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'h1234_5678, 0, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'h1234_5678, 321, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'h1234_5678, 642, 1},
        // full-width line, cut short by the next command
        '{0, MODE_LINE, 0, 0, 2047, 0, 32'h0F0F_0F0F, 0, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'h0F0F_0F0F, 0, 0},
        '{1, MODE_STEP, 0, 0, 0, 0, 32'h0F0F_0F0F, 1, 0},
        '{0, MODE_LINE, 10, 0, 9, 1, 32'hF0F0_F0F0, 0, 0},
        '{0, MODE_STEP, 0, 0, 0, 0, 32'h0000_0000, 0, 0},
        '{0, MODE_STEP, 0, 0, 0, 0, 32'h0000_0000, 0, 0},
        // anti-diagonal across the whole surface, replaced mid-line later
        '{0, MODE_LINE, 2047, 0, 0, 2047, 32'h8000_0001, 0, 0},
        '{0, MODE_STEP, 0, 0, 0, 0, 32'h0000_0000, 0, 0}
    };

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // input stream
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // start_x, start_y, end_x, end_y, line_color, zero pad
    logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
    // mode
    logic                    s_axis_tuser = MODE_LINE;

    // output stream
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // pixel_address, pixel_color, zero pad
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    // last_pixel
    logic                     m_axis_tlast;

    // register port
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    line_rasterizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // line walker: the testbench's own copy of the drawing state
    // ---------------------------------------------------------------
    bit [WIDTH_BITS-1:0] pen_width = SURFACE_WIDTH_RESET;
    bit                  pen_on;
    bit [ADDR_BITS-1:0]  pen_addr;
    bit [LEN_BITS-1:0]   pen_left;
    bit [LEN_BITS-1:0]   pen_err;
    bit [LEN_BITS-1:0]   pen_major_len;
    bit [LEN_BITS-1:0]   pen_minor_len;
    bit [ADDR_BITS-1:0]  pen_major_step;
    bit [ADDR_BITS-1:0]  pen_minor_step;
    bit [COLOR_BITS-1:0] pen_color;

    // framebuffer writes still owed by the block, oldest first
    t_pixel pixels_due [$];

    int  mismatches = 0;
    int  items_sent = 0;
    bit  tx_gaps = 1'b1;
    bit  rx_gaps = 1'b1;
    int  rx_hold_left = 0;

    // advance the walker by one accepted transfer
    function automatic void rasterize(input t_cmd c, output bit emits, output t_pixel px);
        bit [COORD_BITS-1:0] adx;
        bit [COORD_BITS-1:0] ady;
        bit [ADDR_BITS-1:0]  xs;
        bit [ADDR_BITS-1:0]  ys;
        bit [31:0]           origin;
        emits = 1'b0;
        px = '0;
        if (c.mode == MODE_LINE) begin
            if (c.ex >= c.sx) begin
                adx = c.ex - c.sx;
                xs = ADDR_BITS'(1);
            end else begin
                adx = c.sx - c.ex;
                xs = '1;
            end
            if (c.ey >= c.sy) begin
                ady = c.ey - c.sy;
                ys = ADDR_BITS'(pen_width);
            end else begin
                ady = c.sy - c.ey;
                ys = ~ADDR_BITS'(pen_width) + 1'b1;
            end
            // ties go to the horizontal direction
            if (adx < ady) begin
                pen_major_len = LEN_BITS'(ady) + 1'b1;
                pen_minor_len = LEN_BITS'(adx) + 1'b1;
                pen_major_step = ys;
                pen_minor_step = xs;
            end else begin
                pen_major_len = LEN_BITS'(adx) + 1'b1;
                pen_minor_len = LEN_BITS'(ady) + 1'b1;
                pen_major_step = xs;
                pen_minor_step = ys;
            end
            origin = c.sx + c.sy * pen_width;
            pen_addr = origin[ADDR_BITS-1:0];
            pen_left = pen_major_len;
            pen_err = '0;
            pen_color = c.color;
            pen_on = 1'b1;
        end else if (pen_on) begin
            emits = 1'b1;
            px.addr = pen_addr;
            px.color = pen_color;
            px.last = (pen_left == LEN_BITS'(1));
            pen_err = pen_err + pen_minor_len;
            if (pen_err >= pen_major_len) begin
                pen_err = pen_err - pen_major_len;
                pen_addr = pen_addr + pen_minor_step;
            end
            pen_addr = pen_addr + pen_major_step;
            pen_left = pen_left - 1'b1;
            if (pen_left == '0) begin
                pen_on = 1'b0;
            end
        end
    endfunction

    // offer one transfer, wait for it to be taken, then log what it owes
    task automatic feed(input t_cmd c, input bit typed, input t_pixel typed_px);
        t_pixel px;
        bit     emits;
        while (tx_gaps && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.mode;
        s_axis_tdata <= IN_DATA_BITS'({c.color, c.ey, c.ex, c.sy, c.sx});
        do @(posedge i_clk); while (!s_axis_tready);
        rasterize(c, emits, px);
        if (emits) begin
            pixels_due.push_back(typed ? typed_px : px);
        end
        items_sent++;
    endtask

    // register write: setup phase, then access phase until pready
    task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == SURFACE_WIDTH_ADDR) begin
            pen_width = value[WIDTH_BITS-1:0];
        end
    endtask

    // stop offering, wait for every owed pixel, then let a pending command settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pixels_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // step transfers carry random payload, which the block must ignore
    function automatic t_cmd random_step();
        t_cmd c;
        c.mode = MODE_STEP;
        c.sx = COORD_BITS'($urandom);
        c.sy = COORD_BITS'($urandom);
        c.ex = COORD_BITS'($urandom);
        c.ey = COORD_BITS'($urandom);
        c.color = $urandom;
        return c;
    endfunction

    // one line command followed by a burst of steps, mostly exactly enough to finish it
    task automatic draw_random_line();
        t_cmd c;
        int   x1, y1, x2, y2, dx, dy, d, tmp;
        int   sel, reach, major, steps, how;
        sel = $urandom_range(99);
        x1 = $urandom_range(COORD_MAX);
        y1 = $urandom_range(COORD_MAX);
        if (sel < 90) begin
            reach = (sel < 60) ? 12 : 60;
            x2 = clamp_coord(x1 + int'($urandom_range(2 * reach)) - reach);
            y2 = clamp_coord(y1 + int'($urandom_range(2 * reach)) - reach);
        end else if (sel < 95) begin
            // flat, upright, diagonal and single-point shapes
            d = $urandom_range(30);
            x1 = $urandom_range(COORD_MAX - 30);
            y1 = $urandom_range(COORD_MAX - 30);
            x2 = x1 + d;
            y2 = y1 + d;
            case ($urandom_range(3))
                0: y2 = y1;
                1: x2 = x1;
                2: ;
                default: begin
                    x2 = x1;
                    y2 = y1;
                end
            endcase
            if ($urandom_range(1)) begin
                tmp = x1; x1 = x2; x2 = tmp;
            end
            if ($urandom_range(1)) begin
                tmp = y1; y1 = y2; y2 = tmp;
            end
        end else begin
            x2 = $urandom_range(COORD_MAX);
            y2 = $urandom_range(COORD_MAX);
        end
        dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
        dy = (y2 >= y1) ? y2 - y1 : y1 - y2;
        major = ((dx > dy) ? dx : dy) + 1;
        how = $urandom_range(99);
        if (how < 10) begin
            steps = $urandom_range(major - 1);
        end else if (how < 20) begin
            steps = major + $urandom_range(1, 3);
        end else begin
            steps = major;
        end
        // long lines are only drawn part way, then replaced
        if (steps > 80) begin
            steps = $urandom_range(1, 80);
        end
        c.mode = MODE_LINE;
        c.sx = COORD_BITS'(x1);
        c.sy = COORD_BITS'(y1);
        c.ex = COORD_BITS'(x2);
        c.ey = COORD_BITS'(y2);
        c.color = $urandom;
        feed(c, 1'b0, '0);
        repeat (steps) feed(random_step(), 1'b0, '0);
    endtask

    // ---------------------------------------------------------------
    // output side: random tready, plus a long hold-off when asked
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else if (rx_gaps) begin
            m_axis_tready <= ($urandom_range(99) >= 31);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare every pixel transfer with the oldest owed write
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("pixel transfer with nothing owed: address %h color %h last %b",
                             m_axis_tdata[ADDR_BITS-1:0],
                             m_axis_tdata[ADDR_BITS +: COLOR_BITS], m_axis_tlast);
                end
            end else begin
                want = pixels_due.pop_front();
                if (m_axis_tdata[ADDR_BITS-1:0] != want.addr) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("pixel_address: expected %h, got %h",
                                 want.addr, m_axis_tdata[ADDR_BITS-1:0]);
                    end
                end
                if (m_axis_tdata[ADDR_BITS +: COLOR_BITS] != want.color) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("pixel_color: expected %h, got %h at address %h",
                                 want.color, m_axis_tdata[ADDR_BITS +: COLOR_BITS], want.addr);
                    end
                end
                if (m_axis_tlast != want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("last_pixel: expected %b, got %b at address %h",
                                 want.last, m_axis_tlast, want.addr);
                    end
                end
            end
        end
    end

    // watchdog: a hung handshake ends the run
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        bit [WIDTH_BITS-1:0] surface_widths [7];
        t_pixel              typed_px;
        t_cmd                c;
        int                  phase_start;
        int                  tmp;

        // extremes first, then a random width, then ordinary sizes
        surface_widths = '{12'd1, 12'd2048, 12'd0, 12'd4095,
                           WIDTH_BITS'($urandom_range(1, 2048)), 12'd640, 12'd320};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows at the reset width
        foreach (opening_table[r]) begin
            c.mode = opening_table[r].mode;
            c.sx = opening_table[r].sx;
            c.sy = opening_table[r].sy;
            c.ex = opening_table[r].ex;
            c.ey = opening_table[r].ey;
            c.color = opening_table[r].color;
            typed_px.addr = opening_table[r].want_addr;
            typed_px.color = opening_table[r].color;
            typed_px.last = opening_table[r].want_last;
            feed(c, opening_table[r].typed, typed_px);
        end

        // random lines under each surface width
        foreach (surface_widths[p]) begin
            drain();
            write_reg(SURFACE_WIDTH_ADDR, {20'($urandom), surface_widths[p]});
            if (p == 2) begin
                // write to an address with no register behind it: must change nothing
                write_reg(SPARE_ADDR, $urandom);
            end
            tx_gaps = (p != 1) && (p != 2);
            rx_gaps = (p != 1);
            if (p == 2) begin
                // receiver goes quiet while the sender keeps pushing steps
                rx_hold_left = HOLD_OFF_CYCLES;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                draw_random_line();
            end
        end

        // one long line, drawn to its very end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        c.mode = MODE_LINE;
        c.sx = COORD_BITS'($urandom_range(COORD_MAX - LONG_SPAN));
        c.ex = c.sx + COORD_BITS'(LONG_SPAN);
        c.sy = COORD_BITS'($urandom_range(COORD_MAX - LONG_SPAN));
        c.ey = c.sy + COORD_BITS'($urandom_range(LONG_SPAN));
        c.color = $urandom;
        if ($urandom_range(1)) begin
            tmp = c.sx; c.sx = c.ex; c.ex = COORD_BITS'(tmp);
        end
        feed(c, 1'b0, '0);
        repeat (LONG_SPAN + 1) feed(random_step(), 1'b0, '0);

        drain();
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
